// ===== hdl/penum_pkg.sv =====
// Shared types and constants of the permutation enumerator.
`timescale 1ns / 1ps

package penum_pkg;

  // Field widths of the transfers and of the register port.
  localparam int ELEM_W = 3;
  localparam int NUM_W  = 16;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Register index decoded from the word address.
  localparam logic REG_PERM_LENGTH = 1'b0;

  // Value of the length register after reset.
  localparam logic [LEN_W-1:0] LEN_RESET = 4'd7;

  // Commands from the sequencer to the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RESET,
    OP_RESTART,
    OP_FIRST,
    OP_P_INIT,
    OP_P_STEP,
    OP_PIV_TAKE,
    OP_Q_STEP,
    OP_SWAP_LO,
    OP_SWAP_HI,
    OP_REV_RD,
    OP_REV_LO,
    OP_REV_HI,
    OP_EMIT_START,
    OP_EMIT_LOAD,
    OP_EXH_LOAD
  } dp_op_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic n_lt2;
    logic pair_rise;
    logic p_at_one;
    logic q_above;
    logic lo_lt_hi;
    logic rev_more;
    logic i_last;
    logic slot_free;
  } dp_status_t;

endpackage

// ===== hdl/penum_dp.sv =====
// Datapath: arrangement memory, scan indices, run counter and result register.
`timescale 1ns / 1ps

module penum_dp #(
  parameter int MAX_LEN = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [$clog2(MAX_LEN + 1) - 1:0]    n,
  input  penum_pkg::dp_op_t                   op,
  output penum_pkg::dp_status_t               status,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [penum_pkg::ELEM_W-1:0]        element,
  output logic                                last_of_run,
  output logic [penum_pkg::NUM_W-1:0]         perm_number,
  output logic                                exhausted
);

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  // Arrangement store; an entry that is not valid holds its own index.
  logic [penum_pkg::ELEM_W-1:0] mem [MAX_LEN];
  logic [MAX_LEN-1:0]           vld;

  logic [IDX_W-1:0]             p;
  logic [IDX_W-1:0]             q;
  logic [IDX_W-1:0]             lo;
  logic [IDX_W-1:0]             hi;
  logic [IDX_W-1:0]             idx;
  logic [penum_pkg::ELEM_W-1:0] rd_a;
  logic [penum_pkg::ELEM_W-1:0] rd_b;
  logic [penum_pkg::ELEM_W-1:0] pv;
  logic [penum_pkg::NUM_W-1:0]  count;

  logic                         rd_en_a;
  logic                         rd_en_b;
  logic [IDX_W-1:0]             addr_a;
  logic [IDX_W-1:0]             addr_b;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [penum_pkg::ELEM_W-1:0] wr_data;
  logic                         clear;
  logic [IDX_W-1:0]             top_idx;
  logic                         slot_free;
  logic                         out_load;

  assign top_idx   = IDX_W'(n - CNT_W'(1));
  assign clear     = (op == penum_pkg::OP_RESET) || (op == penum_pkg::OP_RESTART);
  assign slot_free = !res_valid || !res_stall;
  assign out_load  = (op == penum_pkg::OP_EMIT_LOAD) || (op == penum_pkg::OP_EXH_LOAD);

  // Status toward the sequencer.
  always_comb begin
    status.n_lt2     = (CNT_W + 1)'(n) < (CNT_W + 1)'(2);
    status.pair_rise = rd_a < rd_b;
    status.p_at_one  = p == IDX_W'(1);
    status.q_above   = rd_b > pv;
    status.lo_lt_hi  = ((CNT_W + 1)'(p) + (CNT_W + 1)'(2)) < (CNT_W + 1)'(n);
    status.rev_more  = ((IDX_W + 1)'(lo) + (IDX_W + 1)'(2)) < (IDX_W + 1)'(hi);
    status.i_last    = (CNT_W'(idx) + CNT_W'(1)) == n;
    status.slot_free = slot_free;
  end

  // Memory port addresses and write data for each command.
  always_comb begin
    rd_en_a = 1'b0;
    rd_en_b = 1'b0;
    addr_a  = '0;
    addr_b  = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (op)
      penum_pkg::OP_P_INIT: begin
        rd_en_a = 1'b1;
        rd_en_b = 1'b1;
        addr_a  = top_idx - IDX_W'(1);
        addr_b  = top_idx;
      end
      penum_pkg::OP_P_STEP: begin
        rd_en_a = 1'b1;
        rd_en_b = 1'b1;
        addr_a  = p - IDX_W'(2);
        addr_b  = p - IDX_W'(1);
      end
      penum_pkg::OP_PIV_TAKE: begin
        rd_en_b = 1'b1;
        addr_b  = top_idx;
      end
      penum_pkg::OP_Q_STEP: begin
        rd_en_b = 1'b1;
        addr_b  = q - IDX_W'(1);
      end
      penum_pkg::OP_SWAP_LO: begin
        wr_en   = 1'b1;
        wr_addr = p;
        wr_data = rd_b;
      end
      penum_pkg::OP_SWAP_HI: begin
        wr_en   = 1'b1;
        wr_addr = q;
        wr_data = pv;
      end
      penum_pkg::OP_REV_RD: begin
        rd_en_a = 1'b1;
        rd_en_b = 1'b1;
        addr_a  = lo;
        addr_b  = hi;
      end
      penum_pkg::OP_REV_LO: begin
        wr_en   = 1'b1;
        wr_addr = lo;
        wr_data = rd_b;
      end
      penum_pkg::OP_REV_HI: begin
        wr_en   = 1'b1;
        wr_addr = hi;
        wr_data = rd_a;
      end
      penum_pkg::OP_EMIT_START: begin
        rd_en_a = 1'b1;
        addr_a  = '0;
      end
      penum_pkg::OP_EMIT_LOAD: begin
        rd_en_a = !status.i_last;
        addr_a  = idx + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Valid bits: a clear returns the whole arrangement to identity order.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Memory write port and the two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en_a) begin
      rd_a <= vld[addr_a] ? mem[addr_a] : penum_pkg::ELEM_W'(addr_a);
    end
    if (rd_en_b) begin
      rd_b <= vld[addr_b] ? mem[addr_b] : penum_pkg::ELEM_W'(addr_b);
    end
  end

  // Scan and emit indices.
  always_ff @(posedge clk) begin
    unique case (op)
      penum_pkg::OP_P_INIT: begin
        p <= top_idx;
      end
      penum_pkg::OP_P_STEP: begin
        p <= p - IDX_W'(1);
      end
      penum_pkg::OP_PIV_TAKE: begin
        p  <= p - IDX_W'(1);
        pv <= rd_a;
        q  <= top_idx;
      end
      penum_pkg::OP_Q_STEP: begin
        q <= q - IDX_W'(1);
      end
      penum_pkg::OP_SWAP_HI: begin
        lo <= p + IDX_W'(1);
        hi <= top_idx;
      end
      penum_pkg::OP_REV_HI: begin
        lo <= lo + IDX_W'(1);
        hi <= hi - IDX_W'(1);
      end
      penum_pkg::OP_EMIT_START: begin
        idx <= '0;
      end
      penum_pkg::OP_EMIT_LOAD: begin
        idx <= idx + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Running number of the permutation most recently produced.
  always_ff @(posedge clk) begin
    if (rst || op == penum_pkg::OP_RESET) begin
      count <= '0;
    end else if (op == penum_pkg::OP_RESTART || op == penum_pkg::OP_FIRST) begin
      count <= penum_pkg::NUM_W'(1);
    end else if (op == penum_pkg::OP_PIV_TAKE) begin
      count <= count + penum_pkg::NUM_W'(1);
    end
  end

  // Result register; it empties when its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == penum_pkg::OP_EMIT_LOAD) begin
      element     <= rd_a;
      last_of_run <= status.i_last;
      perm_number <= count;
      exhausted   <= 1'b0;
    end else if (op == penum_pkg::OP_EXH_LOAD) begin
      element     <= '0;
      last_of_run <= 1'b1;
      perm_number <= '0;
      exhausted   <= 1'b1;
    end
  end

endmodule

// ===== hdl/penum_ctrl.sv =====
// Sequencer that steps the datapath through the next-permutation algorithm.
`timescale 1ns / 1ps

module penum_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  restart,
  input  penum_pkg::dp_status_t status,
  output penum_pkg::dp_op_t     op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PIV,
    S_QS,
    S_SW2,
    S_REV_RD,
    S_REV_LO,
    S_REV_HI,
    S_EMIT_GO,
    S_EMIT,
    S_EXH
  } state_t;

  state_t state;
  state_t state_next;
  logic   started;
  logic   started_next;
  logic   finished;
  logic   finished_next;

  // Requests are taken only between runs and never alongside a register write.
  assign req_stall = (state != S_IDLE) || cfg_wr;

  // Next state and command.
  always_comb begin
    state_next    = state;
    started_next  = started;
    finished_next = finished;
    op            = penum_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (cfg_wr) begin
          op            = penum_pkg::OP_RESET;
          started_next  = 1'b0;
          finished_next = 1'b0;
        end else if (req_valid) begin
          priority if (restart) begin
            op            = penum_pkg::OP_RESTART;
            started_next  = 1'b1;
            finished_next = 1'b0;
            state_next    = S_EMIT_GO;
          end else if (finished) begin
            state_next = S_EXH;
          end else if (!started) begin
            op           = penum_pkg::OP_FIRST;
            started_next = 1'b1;
            state_next   = S_EMIT_GO;
          end else if (status.n_lt2) begin
            finished_next = 1'b1;
            state_next    = S_EXH;
          end else begin
            op         = penum_pkg::OP_P_INIT;
            state_next = S_PIV;
          end
        end
      end
      // Walk left until an ascending pair marks the pivot.
      S_PIV: begin
        priority if (status.pair_rise) begin
          op         = penum_pkg::OP_PIV_TAKE;
          state_next = S_QS;
        end else if (status.p_at_one) begin
          finished_next = 1'b1;
          state_next    = S_EXH;
        end else begin
          op = penum_pkg::OP_P_STEP;
        end
      end
      // Walk left from the end to the first entry above the pivot.
      S_QS: begin
        if (status.q_above) begin
          op         = penum_pkg::OP_SWAP_LO;
          state_next = S_SW2;
        end else begin
          op = penum_pkg::OP_Q_STEP;
        end
      end
      S_SW2: begin
        op         = penum_pkg::OP_SWAP_HI;
        state_next = status.lo_lt_hi ? S_REV_RD : S_EMIT_GO;
      end
      // Reverse the tail one pair at a time.
      S_REV_RD: begin
        op         = penum_pkg::OP_REV_RD;
        state_next = S_REV_LO;
      end
      S_REV_LO: begin
        op         = penum_pkg::OP_REV_LO;
        state_next = S_REV_HI;
      end
      S_REV_HI: begin
        op         = penum_pkg::OP_REV_HI;
        state_next = status.rev_more ? S_REV_RD : S_EMIT_GO;
      end
      S_EMIT_GO: begin
        op         = penum_pkg::OP_EMIT_START;
        state_next = S_EMIT;
      end
      // One element per cycle while the result register has room.
      S_EMIT: begin
        if (status.slot_free) begin
          op = penum_pkg::OP_EMIT_LOAD;
          if (status.i_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_EXH: begin
        if (status.slot_free) begin
          op         = penum_pkg::OP_EXH_LOAD;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      started  <= 1'b0;
      finished <= 1'b0;
    end else begin
      state    <= state_next;
      started  <= started_next;
      finished <= finished_next;
    end
  end

endmodule

// ===== hdl/permutation_enumerator_unit.sv =====
// Top level of the lexicographic permutation enumerator with its register port.
//
// Each transfer on the request channel (req_valid, req_stall, restart) produces the
// next permutation of 0..n-1 as a run of n transfers on the result channel
// (res_valid, res_stall, element, last_of_run, perm_number, exhausted).
// restart = 1 starts again from the identity order. Once all permutations
// were given, each request yields one result with exhausted set.
// The length n sits in register perm_length at byte address 0; a write to it
// returns the enumeration to its start. Write it only while the block is idle.
// Flow: one request is taken at a time, when idle. A restart or the first
// request goes straight to fetching the first element; an advance takes a
// start step, a pivot scan, a successor scan that ends with the first swap
// write, the second swap write, a read, low write and high write for each
// pair of the tail reversal and a fetch of the first element, all set by the
// single write port of the arrangement memory. Elements then leave at one per
// cycle while the result channel does not stall. A stall on the result
// channel holds the result register and pauses the run. Reset sets n to 7 and
// the identity order.
`timescale 1ns / 1ps

module permutation_enumerator_unit #(
  parameter int MAX_LEN = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [penum_pkg::ADDR_W-1:0]     paddr,
  input  logic [penum_pkg::DATA_W-1:0]     pwdata,
  output logic [penum_pkg::DATA_W-1:0]     prdata,
  output logic                             pready,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             restart,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [penum_pkg::ELEM_W-1:0]     element,
  output logic                             last_of_run,
  output logic [penum_pkg::NUM_W-1:0]      perm_number,
  output logic                             exhausted
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [penum_pkg::LEN_W-1:0] perm_length;
  logic                        reg_sel;
  logic                        cfg_wr;
  logic [CNT_W-1:0]            n;
  penum_pkg::dp_op_t           op;
  penum_pkg::dp_status_t       status;

  // Register access decode.
  assign pready  = 1'b1;
  assign reg_sel = paddr[penum_pkg::ADDR_W-1] == penum_pkg::REG_PERM_LENGTH;
  assign cfg_wr  = psel && penable && pwrite && reg_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_length <= penum_pkg::LEN_RESET;
    end else if (cfg_wr) begin
      perm_length <= pwdata[penum_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = penum_pkg::DATA_W'(perm_length);
    end
  end

  // Active length: zero counts as one, large values saturate.
  always_comb begin
    priority if (perm_length == '0) begin
      n = CNT_W'(1);
    end else if (perm_length > penum_pkg::LEN_W'(MAX_LEN)) begin
      n = CNT_W'(MAX_LEN);
    end else begin
      n = CNT_W'(perm_length);
    end
  end

  penum_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .restart   (restart),
    .status    (status),
    .op        (op)
  );

  penum_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .n           (n),
    .op          (op),
    .status      (status),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .element     (element),
    .last_of_run (last_of_run),
    .perm_number (perm_number),
    .exhausted   (exhausted)
  );

endmodule
